// ===== rtl/quadrature_pid_position_loop_assert.svh =====
// Assertion macros for the quadrature position loop.
// Included by the top level; expects clk and rst in scope.
`ifndef QUADRATURE_PID_POSITION_LOOP_ASSERT_SVH
`define QUADRATURE_PID_POSITION_LOOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define QPPL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define QPPL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/qppl_pkg.sv =====
// Shared types and constants for the quadrature position loop.
// Used by qppl_ctrl, qppl_dp and quadrature_pid_position_loop; no dependencies.
package qppl_pkg;

  localparam int CFG_INDEX_W          = 3;
  localparam int CFG_DATA_W           = 32;
  localparam int PERIOD_FRACTION_BITS = 24;
  localparam int MUL_W                = 33;
  localparam int PROD_W               = 2 * MUL_W;
  localparam int ACC_W                = 112;
  localparam int INTEGRAL_W           = 40;
  localparam int ISUM_W               = 58;
  localparam int DERIV_W              = 53;

  localparam logic signed [31:0] GAIN_P_RESET   = 32'sd655360;
  localparam logic signed [31:0] GAIN_I_RESET   = 32'sd0;
  localparam logic signed [31:0] GAIN_D_RESET   = 32'sd0;
  localparam logic [23:0]        PERIOD_RESET   = 24'd16777;
  localparam logic [19:0]        RATE_INV_RESET = 20'd1000;
  localparam logic [15:0]        LIMIT_RESET    = 16'd1000;

  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  // Quadrature transition table, indexed by {previous pair, current pair}.
  localparam logic signed [1:0] STEP_TABLE [16] = '{
    2'sd0,  -2'sd1, 2'sd1,  2'sd0,
    2'sd1,  2'sd0,  2'sd0,  -2'sd1,
    -2'sd1, 2'sd0,  2'sd0,  2'sd1,
    2'sd0,  2'sd1,  -2'sd1, 2'sd0
  };

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_GAIN_P   = 3'd0,
    CFG_GAIN_I   = 3'd1,
    CFG_GAIN_D   = 3'd2,
    CFG_PERIOD   = 3'd3,
    CFG_RATE_INV = 3'd4,
    CFG_LIMIT    = 3'd5
  } cfg_index_t;

  typedef enum logic [2:0] {
    MUL_ERR_PERIOD,
    MUL_DIFF_RATE,
    MUL_P_ERR,
    MUL_I_LO,
    MUL_I_HI,
    MUL_D_LO,
    MUL_D_HI
  } mul_sel_t;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_CLEAR,
    ACC_ADD0,
    ACC_ADD24,
    ACC_ADD48
  } acc_op_t;

  typedef struct packed {
    logic     take;
    logic     load_count_out;
    logic     load_err;
    logic     load_diff;
    logic     upd_integral;
    logic     load_deriv;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    logic     finish;
  } cmd_t;

endpackage

// ===== rtl/qppl_ctrl.sv =====
// Sequencer for the quadrature position loop: handshakes and PID step order.
// Depends on qppl_pkg; drives qppl_dp through qppl_pkg::cmd_t.
module qppl_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              control_tick,
  input  logic              out_ready,
  output logic              in_ready,
  output logic              out_valid,
  output qppl_pkg::cmd_t    cmd
);

  typedef enum logic [10:0] {
    ST_IDLE = 11'b000_0000_0001,
    ST_ERR  = 11'b000_0000_0010,
    ST_MULI = 11'b000_0000_0100,
    ST_INTG = 11'b000_0000_1000,
    ST_DER  = 11'b000_0001_0000,
    ST_PROP = 11'b000_0010_0000,
    ST_ILO  = 11'b000_0100_0000,
    ST_IHI  = 11'b000_1000_0000,
    ST_DLO  = 11'b001_0000_0000,
    ST_DHI  = 11'b010_0000_0000,
    ST_SAT  = 11'b100_0000_0000
  } state_t;

  state_t state;
  state_t state_next;
  logic   slot_free;

  assign slot_free = !out_valid || out_ready;

  always_comb begin
    state_next         = state;
    in_ready           = 1'b0;
    cmd                = '0;
    cmd.mul_sel        = qppl_pkg::MUL_ERR_PERIOD;
    cmd.acc_op         = qppl_pkg::ACC_HOLD;
    unique case (state)
      ST_IDLE: begin
        in_ready = slot_free;
        if (in_valid && slot_free) begin
          cmd.take = 1'b1;
          if (control_tick) begin
            state_next = ST_ERR;
          end else begin
            cmd.load_count_out = 1'b1;
          end
        end
      end
      ST_ERR: begin
        cmd.load_err = 1'b1;
        state_next   = ST_MULI;
      end
      ST_MULI: begin
        cmd.mul_sel   = qppl_pkg::MUL_ERR_PERIOD;
        cmd.load_diff = 1'b1;
        state_next    = ST_INTG;
      end
      ST_INTG: begin
        cmd.upd_integral = 1'b1;
        cmd.mul_sel      = qppl_pkg::MUL_DIFF_RATE;
        state_next       = ST_DER;
      end
      ST_DER: begin
        cmd.load_deriv = 1'b1;
        cmd.mul_sel    = qppl_pkg::MUL_P_ERR;
        cmd.acc_op     = qppl_pkg::ACC_CLEAR;
        state_next     = ST_PROP;
      end
      ST_PROP: begin
        cmd.mul_sel = qppl_pkg::MUL_I_LO;
        cmd.acc_op  = qppl_pkg::ACC_ADD24;
        state_next  = ST_ILO;
      end
      ST_ILO: begin
        cmd.mul_sel = qppl_pkg::MUL_I_HI;
        cmd.acc_op  = qppl_pkg::ACC_ADD0;
        state_next  = ST_IHI;
      end
      ST_IHI: begin
        cmd.mul_sel = qppl_pkg::MUL_D_LO;
        cmd.acc_op  = qppl_pkg::ACC_ADD24;
        state_next  = ST_DLO;
      end
      ST_DLO: begin
        cmd.mul_sel = qppl_pkg::MUL_D_HI;
        cmd.acc_op  = qppl_pkg::ACC_ADD24;
        state_next  = ST_DHI;
      end
      ST_DHI: begin
        cmd.acc_op = qppl_pkg::ACC_ADD48;
        state_next = ST_SAT;
      end
      ST_SAT: begin
        if (slot_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_count_out || cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/qppl_dp.sv =====
// Datapath for the quadrature position loop: counter, PID state, shared multiplier.
// Depends on qppl_pkg; steered by qppl_ctrl through qppl_pkg::cmd_t.
module qppl_dp #(
  parameter int PW  = 32,
  parameter int GFB = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [qppl_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [qppl_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 pin_a,
  input  logic                                 pin_b,
  input  logic signed [31:0]                   target_position,
  input  qppl_pkg::cmd_t                       cmd,
  output logic signed [31:0]                   position_count,
  output logic signed [31:0]                   drive_rate,
  output logic                                 rate_updated
);

  localparam int EW     = ((PW > 32) ? PW : 32) + 1;
  localparam int SH     = GFB + qppl_pkg::PERIOD_FRACTION_BITS;
  localparam int MW     = qppl_pkg::MUL_W;
  localparam int PRW    = qppl_pkg::PROD_W;
  localparam int AW     = qppl_pkg::ACC_W;
  localparam int IW     = qppl_pkg::INTEGRAL_W;
  localparam int SW     = qppl_pkg::ISUM_W;
  localparam int DW     = qppl_pkg::DERIV_W;
  localparam int FB     = qppl_pkg::PERIOD_FRACTION_BITS;

  logic signed [31:0]    gain_p;
  logic signed [31:0]    gain_i;
  logic signed [31:0]    gain_d;
  logic [23:0]           period_frac;
  logic [19:0]           rate_inv;
  logic [15:0]           integral_limit;

  logic [1:0]            last_pair;
  logic [PW-1:0]         position;
  logic signed [31:0]    prev_err;
  logic signed [IW-1:0]  integral;
  logic signed [31:0]    current_rate;

  logic signed [31:0]    target_q;
  logic signed [31:0]    err;
  logic signed [MW-1:0]  diff;
  logic signed [DW-1:0]  deriv;
  logic signed [PRW-1:0] prod;
  logic signed [AW-1:0]  acc;

  logic [1:0]            pair;
  logic signed [1:0]     delta;
  logic [PW-1:0]         pos_next;
  logic signed [EW-1:0]  err_wide;
  logic                  err_fits;
  logic signed [31:0]    err_next;
  logic signed [SW-1:0]  isum;
  logic signed [SW-1:0]  lim_wide;
  logic signed [SW-1:0]  hi_bound;
  logic signed [SW-1:0]  lo_bound;
  logic signed [IW-1:0]  integral_next;
  logic signed [MW-1:0]  mul_a;
  logic signed [MW-1:0]  mul_b;
  logic signed [AW-1:0]  prod_ext;
  logic signed [AW-1:0]  acc_sh;
  logic                  rate_fits;
  logic signed [31:0]    rate_next;

  assign pair     = {pin_a, pin_b};
  assign delta    = qppl_pkg::STEP_TABLE[{last_pair, pair}];
  assign pos_next = position + {{(PW-2){delta[1]}}, delta};

  assign err_wide = {{(EW-32){target_q[31]}}, target_q}
                  - {{(EW-PW){position[PW-1]}}, position};
  assign err_fits = (&err_wide[EW-1:31]) || !(|err_wide[EW-1:31]);
  assign err_next = err_fits ? err_wide[31:0]
                  : (err_wide[EW-1] ? qppl_pkg::S32_MIN : qppl_pkg::S32_MAX);

  assign isum     = {{(SW-IW){integral[IW-1]}}, integral} + prod[SW-1:0];
  assign lim_wide = {{(SW-16-FB){1'b0}}, integral_limit, {FB{1'b0}}};
  assign hi_bound = integral_limit[15] ? {{(SW-IW+1){1'b0}}, {(IW-1){1'b1}}} : lim_wide;
  assign lo_bound = integral_limit[15] ? {{(SW-IW+1){1'b1}}, {(IW-1){1'b0}}} : -lim_wide;

  always_comb begin
    priority if (isum > hi_bound) begin
      integral_next = hi_bound[IW-1:0];
    end else if (isum < lo_bound) begin
      integral_next = lo_bound[IW-1:0];
    end else begin
      integral_next = isum[IW-1:0];
    end
  end

  always_comb begin
    unique case (cmd.mul_sel)
      qppl_pkg::MUL_ERR_PERIOD: begin
        mul_a = {err[31], err};
        mul_b = {{(MW-24){1'b0}}, period_frac};
      end
      qppl_pkg::MUL_DIFF_RATE: begin
        mul_a = diff;
        mul_b = {{(MW-20){1'b0}}, rate_inv};
      end
      qppl_pkg::MUL_P_ERR: begin
        mul_a = {gain_p[31], gain_p};
        mul_b = {err[31], err};
      end
      qppl_pkg::MUL_I_LO: begin
        mul_a = {gain_i[31], gain_i};
        mul_b = {{(MW-FB){1'b0}}, integral[FB-1:0]};
      end
      qppl_pkg::MUL_I_HI: begin
        mul_a = {gain_i[31], gain_i};
        mul_b = {{(MW-IW+FB){integral[IW-1]}}, integral[IW-1:FB]};
      end
      qppl_pkg::MUL_D_LO: begin
        mul_a = {gain_d[31], gain_d};
        mul_b = {{(MW-FB){1'b0}}, deriv[FB-1:0]};
      end
      qppl_pkg::MUL_D_HI: begin
        mul_a = {gain_d[31], gain_d};
        mul_b = {{(MW-DW+FB){deriv[DW-1]}}, deriv[DW-1:FB]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_ext  = {{(AW-PRW){prod[PRW-1]}}, prod};
  assign acc_sh    = acc >>> SH;
  assign rate_fits = (&acc_sh[AW-1:31]) || !(|acc_sh[AW-1:31]);
  assign rate_next = rate_fits ? acc_sh[31:0]
                   : (acc[AW-1] ? qppl_pkg::S32_MIN : qppl_pkg::S32_MAX);

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p         <= qppl_pkg::GAIN_P_RESET;
      gain_i         <= qppl_pkg::GAIN_I_RESET;
      gain_d         <= qppl_pkg::GAIN_D_RESET;
      period_frac    <= qppl_pkg::PERIOD_RESET;
      rate_inv       <= qppl_pkg::RATE_INV_RESET;
      integral_limit <= qppl_pkg::LIMIT_RESET;
      last_pair      <= '0;
      position       <= '0;
      prev_err       <= '0;
      integral       <= '0;
      current_rate   <= '0;
    end else begin
      if (cfg_write) begin
        unique case (qppl_pkg::cfg_index_t'(cfg_index))
          qppl_pkg::CFG_GAIN_P:   gain_p         <= cfg_data[31:0];
          qppl_pkg::CFG_GAIN_I:   gain_i         <= cfg_data[31:0];
          qppl_pkg::CFG_GAIN_D:   gain_d         <= cfg_data[31:0];
          qppl_pkg::CFG_PERIOD:   period_frac    <= cfg_data[23:0];
          qppl_pkg::CFG_RATE_INV: rate_inv       <= cfg_data[19:0];
          qppl_pkg::CFG_LIMIT:    integral_limit <= cfg_data[15:0];
          default: begin
          end
        endcase
      end
      if (cmd.take) begin
        position  <= pos_next;
        last_pair <= pair;
      end
      if (cmd.upd_integral) begin
        integral <= integral_next;
      end
      if (cmd.finish) begin
        prev_err     <= err;
        current_rate <= rate_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (cmd.take) begin
      target_q <= target_position;
    end
    if (cmd.load_err) begin
      err <= err_next;
    end
    if (cmd.load_diff) begin
      diff <= {err[31], err} - {prev_err[31], prev_err};
    end
    if (cmd.load_deriv) begin
      deriv <= prod[DW-1:0];
    end
    unique case (cmd.acc_op)
      qppl_pkg::ACC_HOLD:  acc <= acc;
      qppl_pkg::ACC_CLEAR: acc <= '0;
      qppl_pkg::ACC_ADD0:  acc <= acc + prod_ext;
      qppl_pkg::ACC_ADD24: acc <= acc + (prod_ext <<< 24);
      qppl_pkg::ACC_ADD48: acc <= acc + (prod_ext <<< 48);
      default:             acc <= acc;
    endcase
    if (cmd.load_count_out) begin
      position_count <= 32'(pos_next);
      drive_rate     <= current_rate;
      rate_updated   <= 1'b0;
    end else if (cmd.finish) begin
      position_count <= 32'(position);
      drive_rate     <= rate_next;
      rate_updated   <= 1'b1;
    end
  end

endmodule

// ===== rtl/quadrature_pid_position_loop.sv =====
// Top level of the quadrature-counted position loop with fixed-point PID.
// Depends on qppl_pkg, qppl_ctrl, qppl_dp and quadrature_pid_position_loop_assert.svh.
//
//   channel | signals                                                       | direction
//   --------+---------------------------------------------------------------+----------
//   cfg     | cfg_write, cfg_index, cfg_data                                | in
//   in      | in_valid/in_ready, pin_a, pin_b, target_position, control_tick | in
//   out     | out_valid/out_ready, position_count, drive_rate, rate_updated | out
//
// A count-only transaction loads its result on acceptance; a tick transaction holds the loop through
// the accept, the error, the steps that run seven products through the one 33x33 multiplier
// into the integral, the derivative and the accumulator, and the saturation.
// Input is taken only in idle, while the output register is empty or being drained.
// Reset is synchronous; gains and limits return to their defaults, state to zero.
// A stalled output holds the loop in its final step until the result is taken.
module quadrature_pid_position_loop #(
  parameter int POSITION_WIDTH     = 32,
  parameter int GAIN_FRACTION_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [qppl_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [qppl_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             pin_a,
  input  logic                             pin_b,
  input  logic signed [31:0]               target_position,
  input  logic                             control_tick,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [31:0]               position_count,
  output logic signed [31:0]               drive_rate,
  output logic                             rate_updated
);

  `include "quadrature_pid_position_loop_assert.svh"

  qppl_pkg::cmd_t cmd;

  qppl_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .control_tick (control_tick),
    .out_ready    (out_ready),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .cmd          (cmd)
  );

  qppl_dp #(
    .PW  (POSITION_WIDTH),
    .GFB (GAIN_FRACTION_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .pin_a           (pin_a),
    .pin_b           (pin_b),
    .target_position (target_position),
    .cmd             (cmd),
    .position_count  (position_count),
    .drive_rate      (drive_rate),
    .rate_updated    (rate_updated)
  );

  `QPPL_ASSERT_NOW(a_ready_needs_slot, in_ready, !out_valid || out_ready, "input taken while result blocked")
  `QPPL_ASSERT_NEXT(a_tick_goes_busy, in_valid && in_ready && control_tick, !in_ready && !out_valid, "tick transaction did not start the loop")
  `QPPL_ASSERT_NEXT(a_count_result, in_valid && in_ready && !control_tick, out_valid && !rate_updated, "count-only transaction gave no result")
  `QPPL_ASSERT_NEXT(a_finish_result, cmd.finish, out_valid && rate_updated, "finished PID step gave no updated result")

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for quadrature_pid_position_loop: encoder counting and the PID tick.
// Needs qppl_pkg and the block's RTL; results are predicted in-bench and checked in order.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GAIN_FRAC_BITS = 16;
  localparam logic [2:0] CFG_UNMAPPED_LO = 3'd6;
  localparam logic [2:0] CFG_UNMAPPED_HI = 3'd7;
  localparam longint ERR_MAX = 64'sd2147483647;
  localparam longint ERR_MIN = -64'sd2147483648;
  localparam longint INTEGRAL_MAX = (64'sd1 <<< 39) - 64'sd1;
  localparam longint INTEGRAL_MIN = -(64'sd1 <<< 39);

  typedef struct packed {
    logic signed [31:0] pos;
    logic signed [31:0] rate;
    logic               updated;
  } loop_reading_t;

  typedef enum int {DRAIN_FREE, DRAIN_HALF, DRAIN_SPARSE, DRAIN_TOGGLE} drain_mode_t;

  logic               clk;
  logic               rst = 1'b1;
  logic               cfg_write = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               pin_a = 1'b0;
  logic               pin_b = 1'b0;
  logic signed [31:0] target_position = '0;
  logic               control_tick = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] position_count;
  logic signed [31:0] drive_rate;
  logic               rate_updated;

  logic signed [31:0] kp_gain = qppl_pkg::GAIN_P_RESET;
  logic signed [31:0] ki_gain = qppl_pkg::GAIN_I_RESET;
  logic signed [31:0] kd_gain = qppl_pkg::GAIN_D_RESET;
  logic [23:0]        period_frac = qppl_pkg::PERIOD_RESET;
  logic [19:0]        rate_inv = qppl_pkg::RATE_INV_RESET;
  logic [15:0]        integral_cap = qppl_pkg::LIMIT_RESET;

  logic [1:0]         enc_pair = 2'b00;
  logic signed [31:0] enc_position = '0;
  longint             pid_prev_err = 0;
  longint             pid_integral = 0;
  logic signed [31:0] pid_rate = '0;

  loop_reading_t      predicted_readings[$];
  int                 mismatch_count = 0;
  int                 out_hold_cycles = 0;
  int                 burst_left = 0;
  bit                 sender_steady = 1'b0;
  bit                 walk_forward = 1'b1;

  quadrature_pid_position_loop #(
    .POSITION_WIDTH    (32),
    .GAIN_FRACTION_BITS(GAIN_FRAC_BITS)
  ) uut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .pin_a          (pin_a),
    .pin_b          (pin_b),
    .target_position(target_position),
    .control_tick   (control_tick),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .position_count (position_count),
    .drive_rate     (drive_rate),
    .rate_updated   (rate_updated)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic loop_reading_t advance_encoder_loop(input logic a, input logic b,
                                                         input logic signed [31:0] target,
                                                         input logic tick);
    logic [1:0]          pair;
    longint              err, cap, deriv;
    logic signed [127:0] kp_w, ki_w, kd_w, e_w, i_w, d_w, sum_w;
    loop_reading_t       res;
    pair = {a, b};
    if (pair == {~enc_pair[0], enc_pair[1]}) begin
      enc_position = enc_position + 32'sd1;
    end else if (pair == {enc_pair[0], ~enc_pair[1]}) begin
      enc_position = enc_position - 32'sd1;
    end
    enc_pair = pair;
    if (tick) begin
      err = longint'(target) - longint'(enc_position);
      if (err > ERR_MAX) err = ERR_MAX;
      if (err < ERR_MIN) err = ERR_MIN;
      pid_integral = pid_integral + err * longint'(period_frac);
      cap = longint'(integral_cap) <<< qppl_pkg::PERIOD_FRACTION_BITS;
      if (pid_integral > cap) pid_integral = cap;
      if (pid_integral < -cap) pid_integral = -cap;
      if (pid_integral > INTEGRAL_MAX) pid_integral = INTEGRAL_MAX;
      if (pid_integral < INTEGRAL_MIN) pid_integral = INTEGRAL_MIN;
      deriv = (err - pid_prev_err) * longint'(rate_inv);
      kp_w = kp_gain;
      ki_w = ki_gain;
      kd_w = kd_gain;
      e_w = err;
      i_w = pid_integral;
      d_w = deriv;
      sum_w = ((kp_w * e_w) <<< qppl_pkg::PERIOD_FRACTION_BITS) + ki_w * i_w
            + ((kd_w * d_w) <<< qppl_pkg::PERIOD_FRACTION_BITS);
      sum_w = sum_w >>> (GAIN_FRAC_BITS + qppl_pkg::PERIOD_FRACTION_BITS);
      if (sum_w > ERR_MAX) sum_w = ERR_MAX;
      if (sum_w < ERR_MIN) sum_w = ERR_MIN;
      pid_rate = sum_w[31:0];
      pid_prev_err = err;
    end
    res.pos = enc_position;
    res.rate = pid_rate;
    res.updated = tick;
    return res;
  endfunction

  task automatic send_sample(input logic a, input logic b, input logic signed [31:0] target,
                             input logic tick);
    in_valid <= 1'b1;
    pin_a <= a;
    pin_b <= b;
    target_position <= target;
    control_tick <= tick;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted_readings.push_back(advance_encoder_loop(a, b, target, tick));
  endtask

  task automatic pace_sender();
    int gap;
    if (sender_steady) return;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 12);
    gap = $urandom_range(1, 9);
    in_valid <= 1'b0;
    repeat (gap) @(posedge clk);
  endtask

  task automatic drain_results();
    if (in_valid) in_valid <= 1'b0;
    while (predicted_readings.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [2:0] index, input logic [31:0] data);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    @(posedge clk);
    case (index)
      qppl_pkg::CFG_GAIN_P:   kp_gain = data;
      qppl_pkg::CFG_GAIN_I:   ki_gain = data;
      qppl_pkg::CFG_GAIN_D:   kd_gain = data;
      qppl_pkg::CFG_PERIOD:   period_frac = data[23:0];
      qppl_pkg::CFG_RATE_INV: rate_inv = data[19:0];
      qppl_pkg::CFG_LIMIT:    integral_cap = data[15:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [31:0] kp, input logic [31:0] ki,
                                input logic [31:0] kd, input logic [31:0] period,
                                input logic [31:0] rate, input logic [31:0] cap);
    write_register(CFG_UNMAPPED_LO, $urandom);
    write_register(qppl_pkg::CFG_GAIN_P, kp);
    write_register(qppl_pkg::CFG_GAIN_I, ki);
    write_register(qppl_pkg::CFG_GAIN_D, kd);
    write_register(qppl_pkg::CFG_PERIOD, period);
    write_register(qppl_pkg::CFG_RATE_INV, rate);
    write_register(qppl_pkg::CFG_LIMIT, cap);
    write_register(CFG_UNMAPPED_HI, $urandom);
    cfg_write <= 1'b0;
  endtask

  function automatic logic [31:0] random_gain();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
  endfunction

  task automatic send_motion_sample(input int tick_pct);
    int                 pick;
    logic [1:0]         pair;
    logic signed [31:0] target;
    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      pair = ~enc_pair;
    end else if (pick < 8) begin
      pair = 2'($urandom_range(0, 3));
    end else if (pick < 22) begin
      pair = enc_pair;
    end else begin
      if ($urandom_range(0, 19) == 0) walk_forward = !walk_forward;
      pair = walk_forward ? {~enc_pair[0], enc_pair[1]} : {enc_pair[0], ~enc_pair[1]};
    end
    pick = $urandom_range(0, 99);
    if (pick < 70) target = enc_position + 32'($urandom_range(0, 400)) - 32'sd200;
    else if (pick < 85) target = $urandom;
    else if (pick < 92) target = $urandom_range(0, 1) ? qppl_pkg::S32_MAX : qppl_pkg::S32_MIN;
    else target = $urandom_range(0, 4000) - 2000;
    send_sample(pair[1], pair[0], target, $urandom_range(0, 99) < tick_pct);
    pace_sender();
  endtask

  task automatic check_result();
    loop_reading_t want;
    if (predicted_readings.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("unexpected transaction: position %0d rate %0d updated %0b",
                 position_count, drive_rate, rate_updated);
      return;
    end
    want = predicted_readings.pop_front();
    if (want.pos !== position_count || want.rate !== drive_rate
        || want.updated !== rate_updated) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("mismatch at %0t: position %0d/%0d rate %0d/%0d updated %0b/%0b (exp/act)",
                 $realtime, want.pos, position_count, want.rate, drive_rate,
                 want.updated, rate_updated);
    end
  endtask

  initial begin : result_monitor
    drain_mode_t mode;
    int          mode_left;
    mode = DRAIN_FREE;
    mode_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) check_result();
      if (out_hold_cycles > 0) begin
        out_hold_cycles--;
        out_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = drain_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(8, 60);
        end else begin
          mode_left--;
        end
        case (mode)
          DRAIN_FREE:   out_ready <= 1'b1;
          DRAIN_HALF:   out_ready <= 1'($urandom_range(0, 1));
          DRAIN_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
          default:      out_ready <= ~out_ready;
        endcase
      end
    end
  end

  task automatic test_directed_edges();
    send_sample(1'b0, 1'b0, 32'sd0, 1'b0);
    send_sample(1'b1, 1'b0, qppl_pkg::S32_MAX, 1'b0);
    send_sample(1'b1, 1'b1, qppl_pkg::S32_MIN, 1'b0);
    send_sample(1'b0, 1'b1, 32'sd0, 1'b0);
    send_sample(1'b0, 1'b0, qppl_pkg::S32_MIN, 1'b1);
    send_sample(1'b0, 1'b0, qppl_pkg::S32_MAX, 1'b1);
    send_sample(1'b0, 1'b1, 32'sd0, 1'b0);
    send_sample(1'b1, 1'b1, 32'sd0, 1'b0);
    send_sample(1'b1, 1'b0, 32'sd0, 1'b0);
    send_sample(1'b0, 1'b0, 32'sd0, 1'b0);
    send_sample(1'b0, 1'b1, 32'sd0, 1'b0);
    send_sample(1'b1, 1'b1, 32'sd0, 1'b0);
    send_sample(1'b0, 1'b0, 32'sd5, 1'b1);
    send_sample(1'b1, 1'b1, -32'sd7, 1'b0);
    send_sample(1'b1, 1'b0, qppl_pkg::S32_MAX, 1'b1);
    send_sample(1'b1, 1'b0, qppl_pkg::S32_MIN, 1'b1);
    send_sample(1'b0, 1'b1, 32'sd0, 1'b1);
    send_sample(1'b0, 1'b0, -32'sd1, 1'b1);
    send_sample(1'b0, 1'b0, 32'sd0, 1'b0);
    drain_results();
  endtask

  task automatic test_settings_sweep();
    for (int phase = 0; phase < 9; phase++) begin
      drain_results();
      case (phase)
        0: apply_settings(qppl_pkg::S32_MAX, qppl_pkg::S32_MAX, qppl_pkg::S32_MAX,
                          32'h00FF_FFFF, 32'd1000000, 32'd65535);
        1: apply_settings(qppl_pkg::S32_MIN, qppl_pkg::S32_MIN, qppl_pkg::S32_MIN,
                          32'd1, 32'd1, 32'd0);
        2: apply_settings(random_gain(), random_gain(), random_gain(), 32'd0, 32'd0,
                          $urandom_range(0, 65535));
        3: apply_settings(qppl_pkg::GAIN_P_RESET, qppl_pkg::GAIN_I_RESET,
                          qppl_pkg::GAIN_D_RESET, qppl_pkg::PERIOD_RESET,
                          qppl_pkg::RATE_INV_RESET, qppl_pkg::LIMIT_RESET);
        4: apply_settings(random_gain(), random_gain(), random_gain(), 32'h00FF_FFFF,
                          32'h000F_FFFF, 32'd65535);
        default: apply_settings(random_gain(), random_gain(), random_gain(), $urandom,
                                $urandom, $urandom);
      endcase
      for (int n = 0; n < 190; n++) send_motion_sample(25);
    end
    drain_results();
  endtask

  task automatic test_output_backpressure();
    out_hold_cycles = 300;
    sender_steady = 1'b1;
    for (int n = 0; n < 120; n++) send_motion_sample(30);
    sender_steady = 1'b0;
    drain_results();
  endtask

  task automatic test_drain_pause();
    for (int n = 0; n < 40; n++) send_motion_sample(20);
    drain_results();
    for (int n = 0; n < 40; n++) send_motion_sample(20);
    drain_results();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_edges();
    test_settings_sweep();
    test_output_backpressure();
    test_drain_pause();
    repeat (30) @(posedge clk);
    if (mismatch_count == 0 && predicted_readings.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("end of test: mismatches");
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/qppl_pkg.sv
rtl/qppl_ctrl.sv
rtl/qppl_dp.sv
rtl/quadrature_pid_position_loop.sv
tb/tb.sv
